// ===== hw/rtl/rgbhsv_pkg.sv =====
// Shared types and constants for the 8-bit RGB to HSV converter.
// Used by rgbhsv_div, rgb_to_hsv_8bit_top and the testbench files; depends on nothing else.
package rgbhsv_pkg;

	localparam int CH_W      = 8;
	localparam int NUM_W     = 2 * CH_W;
	localparam int DIV_STEPS = CH_W;
	// max/min stage, numerator stage, one stage per quotient bit, output stage
	localparam int STAGES    = DIV_STEPS + 3;
	localparam int DIV_FIRST = 2;
	localparam int OUT_STAGE = STAGES - 1;

	localparam logic [CH_W-1:0] HUE_OFS_RED   = 8'd0;
	localparam logic [CH_W-1:0] HUE_OFS_GREEN = 8'd85;
	localparam logic [CH_W-1:0] HUE_OFS_BLUE  = 8'd171;
	localparam logic [5:0]      HUE_STEP      = 6'd43;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
	} hsv_t;

	typedef enum logic [1:0] {
		HUE_RED,
		HUE_GREEN,
		HUE_BLUE
	} hue_sel_t;

	typedef struct packed {
		logic [CH_W-1:0] brightness;
		logic            black;
		logic            grey;
		hue_sel_t        sel;
		logic            neg;
	} side_t;

	function automatic logic [CH_W-1:0] hue_base(input hue_sel_t sel);
		logic [CH_W-1:0] base;
		unique case (sel)
			HUE_RED:   base = HUE_OFS_RED;
			HUE_GREEN: base = HUE_OFS_GREEN;
			HUE_BLUE:  base = HUE_OFS_BLUE;
			default:   base = HUE_OFS_RED;
		endcase
		return base;
	endfunction

endpackage

// ===== hw/rtl/rgb_to_hsv_8bit_top.sv =====
// Converts a stream of 8-bit RGB pixels to 8-bit HSV, one result per pixel.
// Depends on rgbhsv_pkg and rgbhsv_div.
//
// Each pixel passes through these stages from acceptance to its result on
// hsv: one stage finds the largest and smallest channel, one forms the two
// dividends, eight stages run the saturation and hue divisions side by side
// one quotient bit per stage, and one stage adds the hue offset and
// registers the result. A pixel can be accepted every clock unless stalled.
// Each stage moves forward when it is empty or its successor moves, so a
// stalled result only backs up the pipeline once every stage holds a pixel.
module rgb_to_hsv_8bit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  rgbhsv_pkg::pix_t   pix,
	output logic               hsv_valid,
	input  logic               hsv_stall,
	output rgbhsv_pkg::hsv_t   hsv
);
	import rgbhsv_pkg::*;

	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] adv;

	// a stage advances if it is empty or its successor advances
	always_comb begin
		adv[OUT_STAGE] = !valid_q[OUT_STAGE] || !hsv_stall;
		for (int k = OUT_STAGE - 1; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign pix_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= pix_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// stage 1: largest and smallest channel, signed difference of the other two
	hue_sel_t        sel;
	logic [CH_W-1:0] hi, lo, dx, dy;

	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sel = HUE_RED;
			hi  = pix.red;
			dx  = pix.green;
			dy  = pix.blue;
		end else if (pix.green >= pix.blue) begin
			sel = HUE_GREEN;
			hi  = pix.green;
			dx  = pix.blue;
			dy  = pix.red;
		end else begin
			sel = HUE_BLUE;
			hi  = pix.blue;
			dx  = pix.red;
			dy  = pix.green;
		end
		lo = pix.red;
		if (pix.green < lo) begin
			lo = pix.green;
		end
		if (pix.blue < lo) begin
			lo = pix.blue;
		end
	end

	logic [CH_W-1:0] hi_s1, span_s1, mag_s1;
	hue_sel_t        sel_s1;
	logic            neg_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			hi_s1   <= hi;
			span_s1 <= hi - lo;
			sel_s1  <= sel;
			neg_s1  <= dx < dy;
			mag_s1  <= (dx < dy) ? dy - dx : dx - dy;
		end
	end

	// stage 2: dividends 255*span and 43*|diff|
	logic [NUM_W-1:0] sat_num_s2, hue_num_s2;
	logic [CH_W-1:0]  span_s2;
	side_t            side_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sat_num_s2 <= {span_s1, {CH_W{1'b0}}} - NUM_W'(span_s1);
			hue_num_s2 <= NUM_W'(mag_s1) * NUM_W'(HUE_STEP);
			span_s2    <= span_s1;
			side_s2    <= '{brightness: hi_s1, black: hi_s1 == '0, grey: span_s1 == '0,
			                sel: sel_s1, neg: neg_s1};
		end
	end

	// division stages
	logic [CH_W-1:0] sat_quo, hue_quo;

	rgbhsv_div u_sat_div (
		.clk (clk),
		.adv (adv[DIV_FIRST +: DIV_STEPS]),
		.num (sat_num_s2),
		.den (side_s2.brightness),
		.quo (sat_quo)
	);

	rgbhsv_div u_hue_div (
		.clk (clk),
		.adv (adv[DIV_FIRST +: DIV_STEPS]),
		.num (hue_num_s2),
		.den (span_s2),
		.quo (hue_quo)
	);

	side_t side_d [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv[DIV_FIRST]) begin
			side_d[0] <= side_s2;
		end
		for (int j = 1; j < DIV_STEPS; j++) begin
			if (adv[DIV_FIRST+j]) begin
				side_d[j] <= side_d[j-1];
			end
		end
	end

	// output stage: offset plus signed quotient, wrap modulo 256
	side_t           side_last;
	logic [CH_W-1:0] base, hue_raw;
	hsv_t            hsv_next;
	hsv_t            hsv_s11;

	always_comb begin
		side_last = side_d[DIV_STEPS-1];
		base      = hue_base(side_last.sel);
		hue_raw   = side_last.neg ? base - hue_quo : base + hue_quo;
		hsv_next.brightness = side_last.brightness;
		hsv_next.saturation = side_last.black ? '0 : sat_quo;
		hsv_next.hue        = (side_last.black || side_last.grey) ? '0 : hue_raw;
	end

	always_ff @(posedge clk) begin
		if (adv[OUT_STAGE]) begin
			hsv_s11 <= hsv_next;
		end
	end

	assign hsv       = hsv_s11;
	assign hsv_valid = valid_q[OUT_STAGE];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (hsv_valid && hsv_stall && valid_q[0]))
		else $error("input stalled while the pipeline had room");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.brightness == '0) |-> (hsv.hue == '0 && hsv.saturation == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_grey_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.saturation == '0) |-> (hsv.hue == '0))
		else $error("grey pixel with nonzero hue");

	a_result_follows_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && !hsv_stall && !valid_q[OUT_STAGE-1]) |=> !hsv_valid)
		else $error("result appeared without a request behind it");

endmodule

// ===== hw/rtl/rgbhsv_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rgbhsv_pkg; the caller owns the valid bits and drives the stage enables.
module rgbhsv_div (
	input  logic                              clk,
	input  logic [rgbhsv_pkg::DIV_STEPS-1:0] adv,
	input  logic [rgbhsv_pkg::NUM_W-1:0]     num,
	input  logic [rgbhsv_pkg::CH_W-1:0]      den,
	output logic [rgbhsv_pkg::CH_W-1:0]      quo
);
	import rgbhsv_pkg::*;

	// quotient must fit in CH_W bits: num < den * 2**CH_W
	logic [NUM_W-1:0] rem_s [DIV_STEPS-1];
	logic [CH_W-1:0]  den_s [DIV_STEPS-1];
	logic [CH_W-1:0]  quo_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - j;
		logic [NUM_W-1:0] rem_in;
		logic [CH_W-1:0]  den_in;
		logic [CH_W-1:0]  quo_in;
		logic [NUM_W:0]   trial;
		logic             take;

		if (j == 0) begin : g_head
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		// try to subtract the divisor aligned to this quotient bit
		assign trial = {1'b0, rem_in} - ((NUM_W+1)'(den_in) << SH);
		assign take  = !trial[NUM_W];

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				quo_s[j] <= quo_in | (CH_W'(take) << SH);
			end
		end

		if (j < DIV_STEPS - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (adv[j]) begin
					rem_s[j] <= take ? trial[NUM_W-1:0] : rem_in;
					den_s[j] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule

// ===== tb/sv/rgb_to_hsv_8bit_chk.sv =====
`timescale 1ns / 1ps
// Checker for rgb_to_hsv_8bit_top: watches both channels, predicts each HSV result.
// Depends on rgbhsv_pkg for the pixel and HSV struct types.
module rgb_to_hsv_8bit_chk
	import rgbhsv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	input  logic pix_stall,
	input  pix_t pix,
	input  logic hsv_valid,
	input  logic hsv_stall,
	input  hsv_t hsv,
	output int   mismatches,
	output int   pending
);

	localparam int FULL_SCALE = 255;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		pix_t src;
		hsv_t want;
	} hsv_expect_t;

	hsv_expect_t expected_hsv[$];
	int          shown = 0;

	function automatic hsv_t convert_pixel(input pix_t p);
		int   r, g, b, hi, lo, span, sat, diff, base;
		hsv_t res;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		res = '0;
		res.brightness = hi[7:0];
		if (hi == 0)
			return res;
		span = hi - lo;
		sat = (FULL_SCALE * span) / hi;
		res.saturation = sat[7:0];
		if (sat == 0 || span == 0)
			return res;
		// ties go to red first, then green
		if (hi == r) begin
			base = int'(HUE_OFS_RED);
			diff = g - b;
		end else if (hi == g) begin
			base = int'(HUE_OFS_GREEN);
			diff = b - r;
		end else begin
			base = int'(HUE_OFS_BLUE);
			diff = r - g;
		end
		// signed division truncates toward zero; wrap modulo 256
		sat = base + (int'(HUE_STEP) * diff) / span;
		res.hue = sat[7:0];
		return res;
	endfunction

	always @(posedge clk) begin
		hsv_expect_t head;
		int          bad;
		if (!arst_n) begin
			mismatches <= 0;
			pending    <= 0;
		end else begin
			bad = mismatches;
			if (hsv_valid && !hsv_stall) begin
				if (expected_hsv.size() == 0) begin
					bad++;
					if (shown < SHOW_LIMIT) begin
						shown++;
						$display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
							hsv.hue, hsv.saturation, hsv.brightness);
					end
				end else begin
					head = expected_hsv.pop_front();
					if (hsv.hue !== head.want.hue || hsv.saturation !== head.want.saturation
						|| hsv.brightness !== head.want.brightness) begin
						bad++;
						if (shown < SHOW_LIMIT) begin
							shown++;
							$display("%0t: rgb=(%0d,%0d,%0d) expected hsv=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
								$time, head.src.red, head.src.green, head.src.blue,
								head.want.hue, head.want.saturation, head.want.brightness,
								hsv.hue, hsv.saturation, hsv.brightness);
						end
					end
				end
			end
			if (pix_valid && !pix_stall)
				expected_hsv.push_back('{src: pix, want: convert_pixel(pix)});
			mismatches <= bad;
			pending    <= expected_hsv.size();
		end
	end

endmodule

// ===== tb/sv/rgb_to_hsv_8bit_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for rgb_to_hsv_8bit_top: clock, reset, pixel stimulus and result stalls.
// Depends on rgbhsv_pkg, the converter RTL and rgb_to_hsv_8bit_chk.
module rgb_to_hsv_8bit_top_tb;
	import rgbhsv_pkg::*;

	localparam int RANDOM_PIXELS = 950;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 25;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix       = '0;
	logic hsv_valid;
	logic hsv_stall = 1'b0;
	hsv_t hsv;
	int   mismatches;
	int   pending;
	int   idle_cycles = 0;
	logic calm_sender = 1'b0;

	always #5 clk = ~clk;

	rgb_to_hsv_8bit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.hsv_valid(hsv_valid),
		.hsv_stall(hsv_stall),
		.hsv      (hsv)
	);

	rgb_to_hsv_8bit_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.mismatches(mismatches),
		.pending   (pending)
	);

	function automatic int pick_gap();
		int r;
		if (calm_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_t random_pixel();
		int   mode;
		pix_t p;
		mode = $urandom_range(0, 9);
		p.red   = 8'($urandom_range(0, 255));
		p.green = 8'($urandom_range(0, 255));
		p.blue  = 8'($urandom_range(0, 255));
		case (mode)
			6: begin
				// tie two channels, often at the top
				case ($urandom_range(0, 2))
					0: p.green = p.red;
					1: p.blue = p.green;
					default: p.blue = p.red;
				endcase
			end
			7: begin
				p.green = p.red;
				p.blue  = p.red;
			end
			8: begin
				p.red   = 8'($urandom_range(0, 3));
				p.green = 8'($urandom_range(0, 3));
				p.blue  = 8'($urandom_range(0, 3));
			end
			9: begin
				case ($urandom_range(0, 2))
					0: p.red = 8'd255;
					1: p.green = 8'd255;
					default: p.blue = 8'd255;
				endcase
			end
			default: ;
		endcase
		return p;
	endfunction

	// entered and left at a falling edge
	task automatic send_pixel(input pix_t p, input int gap);
		pix       <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_rgb(input int r, input int g, input int b);
		pix_t p;
		p.red   = r[7:0];
		p.green = g[7:0];
		p.blue  = b[7:0];
		send_pixel(p, pick_gap());
	endtask

	// result-side backpressure: bursts of stall, with long quiet stretches
	initial begin
		int   r;
		int   run;
		logic level;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				level = 1'b0;
				run = $urandom_range(100, 300);
			end else if (r < 60) begin
				level = 1'b0;
				run = $urandom_range(1, 8);
			end else if (r < 90) begin
				level = 1'b1;
				run = $urandom_range(1, 3);
			end else begin
				level = 1'b1;
				run = $urandom_range(10, 40);
			end
			repeat (run) begin
				@(negedge clk);
				hsv_stall <= level;
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (hsv_valid && !hsv_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners: black, white, grey, primaries, ties, wrapping hue
		send_rgb(0, 0, 0);
		send_rgb(255, 255, 255);
		send_rgb(128, 128, 128);
		send_rgb(1, 1, 1);
		send_rgb(255, 0, 0);
		send_rgb(0, 255, 0);
		send_rgb(0, 0, 255);
		send_rgb(255, 0, 128);
		send_rgb(255, 0, 1);
		send_rgb(0, 10, 200);
		send_rgb(200, 255, 0);
		send_rgb(255, 255, 0);
		send_rgb(0, 255, 255);
		send_rgb(255, 0, 255);
		send_rgb(1, 0, 0);
		send_rgb(255, 254, 254);
		send_rgb(0, 1, 1);
		send_rgb(1, 2, 3);
		send_rgb(170, 85, 0);

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % 100 == 0)
				calm_sender = ($urandom_range(0, 3) == 0);
			if (i == 300 || i == 650) begin
				// drain everything before going on
				send_pixel(random_pixel(), 1);
				while (pending != 0) @(negedge clk);
			end else begin
				send_pixel(random_pixel(), pick_gap());
			end
		end
		pix_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
